[rtl/cfb_pkg.sv]
// Package for the command frame builder: transaction types, frame constants
// and the CRC16-Modbus byte update. No dependencies.
`timescale 1ns / 1ps

package cfb_pkg;

    typedef struct packed {
        logic       first_byte;
        logic       last_byte;
        logic       has_data;
        logic       to_upper;
        logic [7:0] cmd_code;
        logic [7:0] length_field;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_last;
    } t_out_item;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        logic       first;
        logic       data;
        logic       last;
        logic       upper;
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] db;
    } t_cmd;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [7:0]  START_LOWER  = 8'hD0;
    localparam logic [7:0]  START_UPPER  = 8'h70;
    localparam logic [7:0]  TAIL_LOWER   = 8'hD1;
    localparam logic [7:0]  TAIL_UPPER   = 8'h71;
    localparam logic [7:0]  ADDR_LOWER   = 8'h0B;
    localparam logic [7:0]  ADDR_UPPER   = 8'h0A;
    localparam logic [7:0]  ENCODING     = 8'h01;
    localparam logic [7:0]  HEADER_PAD   = 8'h00;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/cfb_front.sv]
// Front part of the frame builder: accepts input transactions, tracks whether
// a frame is open and its destination, and queues commands that yield bytes.
// Depends on cfb_pkg.
`timescale 1ns / 1ps

module cfb_front
    import cfb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    input  t_in_item i_in_item,
    input  logic     i_q_full,
    output logic     full,
    output logic     o_q_push,
    output t_cmd     o_q_cmd
);

    logic r_inside;
    logic r_dest_upper;
    logic n_inside;
    logic n_dest_upper;
    logic accept;
    logic produces;

    assign full   = i_q_full;
    assign accept = push && !i_q_full;

    // Items outside a frame that do not open one, and idle items, yield nothing.
    assign produces = i_in_item.first_byte
                   || (r_inside && (i_in_item.has_data || i_in_item.last_byte));

    assign o_q_push      = accept && produces;
    assign o_q_cmd.first = i_in_item.first_byte;
    assign o_q_cmd.data  = i_in_item.has_data;
    assign o_q_cmd.last  = i_in_item.last_byte;
    assign o_q_cmd.upper = i_in_item.first_byte ? i_in_item.to_upper : r_dest_upper;
    assign o_q_cmd.cmd   = i_in_item.cmd_code;
    assign o_q_cmd.len   = i_in_item.length_field;
    assign o_q_cmd.db    = i_in_item.data_byte;

    always_comb begin
        n_inside     = r_inside;
        n_dest_upper = r_dest_upper;
        if (accept) begin
            if (i_in_item.first_byte) begin
                n_inside     = 1'b1;
                n_dest_upper = i_in_item.to_upper;
            end
            if (produces && i_in_item.last_byte) begin
                n_inside = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside     <= 1'b0;
            r_dest_upper <= 1'b0;
        end else begin
            r_inside     <= n_inside;
            r_dest_upper <= n_dest_upper;
        end
    end

endmodule

[rtl/cfb_queue.sv]
// Short command queue between the front and back parts of the frame builder.
// Depends on cfb_pkg.
`timescale 1ns / 1ps

module cfb_queue
    import cfb_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/cfb_back.sv]
// Back part of the frame builder: walks each queued command through its header,
// payload, tail and CRC bytes into an output register, one byte a cycle while
// that register is free or popped. Depends on cfb_pkg.
`timescale 1ns / 1ps

module cfb_back
    import cfb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_cmd      i_head,
    output logic      o_q_pop,
    input  logic      pop,
    output logic      empty,
    output t_out_item o_out_item
);

    typedef enum logic [3:0] {
        ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5,
        ST_DATA, ST_TAIL, ST_CRC_LO, ST_CRC_HI
    } t_step;

    t_step       r_step;
    logic        r_mid;
    logic [15:0] r_crc;
    logic        r_out_valid;
    t_out_item   r_out;

    t_step       start_step;
    t_step       cur_step;
    t_step       next_step;
    logic [7:0]  cur_byte;
    logic        cur_done;
    logic        feed_crc;
    logic [15:0] crc_base;
    logic        advance;
    logic        emit;

    assign start_step = i_head.first ? ST_H0 : (i_head.data ? ST_DATA : ST_TAIL);
    assign cur_step   = r_mid ? r_step : start_step;
    assign advance    = !r_out_valid || pop;
    assign emit       = advance && !i_q_empty;
    assign o_q_pop    = emit && cur_done;
    assign empty      = !r_out_valid;
    assign o_out_item = r_out;
    assign feed_crc   = (cur_step != ST_CRC_LO) && (cur_step != ST_CRC_HI);
    // The start byte restarts the CRC, which also covers an abandoned frame.
    assign crc_base   = (cur_step == ST_H0) ? CRC_INIT : r_crc;

    always_comb begin
        cur_byte  = HEADER_PAD;
        cur_done  = 1'b0;
        next_step = ST_H0;
        unique case (cur_step)
            ST_H0: begin
                cur_byte  = i_head.upper ? START_UPPER : START_LOWER;
                next_step = ST_H1;
            end
            ST_H1: begin
                cur_byte  = i_head.cmd;
                next_step = ST_H2;
            end
            ST_H2: begin
                cur_byte  = ENCODING;
                next_step = ST_H3;
            end
            ST_H3: begin
                cur_byte  = i_head.upper ? ADDR_UPPER : ADDR_LOWER;
                next_step = ST_H4;
            end
            ST_H4: begin
                cur_byte  = i_head.len;
                next_step = ST_H5;
            end
            ST_H5: begin
                cur_byte  = HEADER_PAD;
                cur_done  = !i_head.data && !i_head.last;
                next_step = i_head.data ? ST_DATA : ST_TAIL;
            end
            ST_DATA: begin
                cur_byte  = i_head.db;
                cur_done  = !i_head.last;
                next_step = ST_TAIL;
            end
            ST_TAIL: begin
                cur_byte  = i_head.upper ? TAIL_UPPER : TAIL_LOWER;
                next_step = ST_CRC_LO;
            end
            ST_CRC_LO: begin
                cur_byte  = r_crc[7:0];
                next_step = ST_CRC_HI;
            end
            ST_CRC_HI: begin
                cur_byte  = r_crc[15:8];
                cur_done  = 1'b1;
                next_step = ST_H0;
            end
            default: begin
                cur_byte  = HEADER_PAD;
                cur_done  = 1'b1;
                next_step = ST_H0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_H0;
            r_mid       <= 1'b0;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out.out_byte   <= cur_byte;
            r_out.run_last   <= cur_done;
            r_out.frame_last <= (cur_step == ST_CRC_HI);
            r_out_valid      <= 1'b1;
            r_mid            <= !cur_done;
            r_step           <= next_step;
            if (feed_crc) begin
                r_crc <= crc_byte(crc_base, cur_byte);
            end else if (cur_step == ST_CRC_HI) begin
                r_crc <= CRC_INIT;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

[rtl/command_frame_builder_crc16.sv]
// Top level of the command frame builder with CRC16-Modbus trailer.
// Depends on cfb_pkg, cfb_front, cfb_queue and cfb_back.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+----------------------
//   input   | push / full          | i_in_item  (t_in_item)
//   result  | pop / empty          | o_out_item (t_out_item)
//
// One input transaction is taken per cycle while full is low; the command
// queue (QUEUE_DEPTH entries) absorbs bursts while bytes are produced.
// While the result is free or popped, the back part emits one byte per cycle; a
// payload-only item yields one byte; a frame adds six header and three trailer bytes.
// Reset is synchronous; the block accepts input once i_rst_n is released.
// A stalled result holds on o_out_item until popped; the queue takes input until full.
`timescale 1ns / 1ps

module command_frame_builder_crc16
    import cfb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    input  logic      pop,
    output logic      empty,
    output t_out_item o_out_item
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_cmd q_in;
    t_cmd q_head;

    cfb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .i_in_item (i_in_item),
        .i_q_full  (q_full),
        .full      (full),
        .o_q_push  (q_push),
        .o_q_cmd   (q_in)
    );

    cfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    cfb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_head     (q_head),
        .o_q_pop    (q_pop),
        .pop        (pop),
        .empty      (empty),
        .o_out_item (o_out_item)
    );

endmodule

[rtl/cfb_checker.sv]
// Port-level checks for the command frame builder, bound to the top level.
// Depends on cfb_pkg.
`timescale 1ns / 1ps

module cfb_checker
    import cfb_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      push,
    input logic      full,
    input logic      pop,
    input logic      empty,
    input t_out_item o_out_item
);

    // The final CRC byte always closes the run of its transaction.
    a_frame_last_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.frame_last) |-> o_out_item.run_last)
        else $error("frame_last without run_last");

    // Reset leaves both sides idle.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!full && empty))
        else $error("block not idle after reset");

    // The queue can only fill up through an accepted push.
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a push");

    // A result that is not taken stays on the ports unchanged.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind command_frame_builder_crc16 cfb_checker u_cfb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .push       (push),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .o_out_item (o_out_item)
);
